// File: hdl/trad_pkg.sv
// Package for the teletext row attribute decoder.
// Holds the word types, the attribute state type and the control code constants.
// It depends on nothing else.
package trad_pkg;

  // One input word: a character cell with its position and lookahead byte.
  typedef struct packed {
    logic [7:0] cell_code;
    logic [7:0] next_code;
    logic [5:0] column;
    logic [4:0] row_index;
    logic       row_start;
  } in_word_t;

  // One result word: what to draw for the cell.
  typedef struct packed {
    logic [6:0] glyph;
    logic [2:0] fg_color;
    logic [2:0] bg_color;
    logic       bg_transparent;
    logic       draw_mosaic;
    logic       separated;
    logic       double_height;
    logic       drawn;
  } out_word_t;

  // Serial attributes carried from cell to cell along a row.
  // Bit 3 of bg marks a transparent background.
  // Bit 0 of box is a pending start box, bit 1 a pending end box.
  typedef struct packed {
    logic [2:0] fg;
    logic [3:0] bg;
    logic       mosaic;
    logic       conceal;
    logic       separated;
    logic       dbl;
    logic       hold;
    logic [1:0] box;
    logic [6:0] held;
  } attr_state_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_REVEAL_HIDDEN    = 2'd0,
    CFG_TRANSPARENT_MODE = 2'd1,
    CFG_SUBTITLE_MODE    = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_index_t;

  // Character and control codes, bit 7 already stripped.
  localparam logic [6:0] CODE_SPACE       = 7'h20;
  localparam logic [6:0] CODE_END_BOX     = 7'h0a;
  localparam logic [6:0] CODE_START_BOX   = 7'h0b;
  localparam logic [6:0] CODE_NORMAL_SIZE = 7'h0c;
  localparam logic [6:0] CODE_DOUBLE_HGT  = 7'h0d;
  localparam logic [6:0] CODE_RESERVED_0E = 7'h0e;
  localparam logic [6:0] CODE_RESERVED_0F = 7'h0f;
  localparam logic [6:0] CODE_CONCEAL     = 7'h18;
  localparam logic [6:0] CODE_CONTIGUOUS  = 7'h19;
  localparam logic [6:0] CODE_SEPARATED   = 7'h1a;
  localparam logic [6:0] CODE_RESERVED_1B = 7'h1b;
  localparam logic [6:0] CODE_BLACK_BG    = 7'h1c;
  localparam logic [6:0] CODE_NEW_BG      = 7'h1d;
  localparam logic [6:0] CODE_HOLD        = 7'h1e;
  localparam logic [6:0] CODE_RELEASE     = 7'h1f;

  // Blast-through capitals: shown as text even in mosaic mode.
  localparam logic [6:0] BLAST_LOW  = 7'h40;
  localparam logic [6:0] BLAST_HIGH = 7'h5f;

  localparam logic [2:0] COLOUR_WHITE = 3'd7;
  localparam logic [3:0] BG_BLACK     = 4'h0;
  localparam logic [3:0] BG_TRANSP    = 4'h8;

  // Last header column that row 0 leaves undrawn; columns 0 to 7 are not drawn.
  localparam logic [5:0] HEADER_LAST_COL = 6'd7;

  // Attribute state at the start of a row with an opaque background.
  localparam attr_state_t ROW_DEFAULT = '{
    fg:        COLOUR_WHITE,
    bg:        BG_BLACK,
    mosaic:    1'b0,
    conceal:   1'b0,
    separated: 1'b0,
    dbl:       1'b0,
    hold:      1'b0,
    box:       2'b00,
    held:      CODE_SPACE
  };

endpackage

// File: hdl/trad_cell.sv
// Per-cell attribute logic for the teletext row attribute decoder.
// Pure combinational: current attributes and one cell in, next attributes and result out.
// Depends on trad_pkg.
module trad_cell import trad_pkg::*; #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 26
) (
  input  attr_state_t state,
  input  in_word_t    cell_word,
  input  logic        reveal_hidden,
  input  logic        transparent_mode,
  input  logic        subtitle_mode,
  output attr_state_t state_next,
  output out_word_t   result
);

  localparam logic [6:0] LAST_COL = 7'(COLUMNS - 1);
  localparam logic [5:0] LAST_ROW = 6'(ROWS - 1);

  always_comb begin
    logic [6:0]  code;
    logic [6:0]  nxt;
    logic        drawn;
    logic        ctrl;
    logic [6:0]  glyph;
    logic        blast;
    attr_state_t s;

    code  = cell_word.cell_code[6:0];
    nxt   = cell_word.next_code[6:0];
    drawn = !((cell_word.row_index == 5'd0) && (cell_word.column <= HEADER_LAST_COL));
    ctrl  = 1'b0;
    glyph = CODE_SPACE;

    // Row start brings the attributes back to their defaults first.
    s = state;
    if (cell_word.row_start) begin
      s = ROW_DEFAULT;
      if (subtitle_mode || transparent_mode) begin
        s.bg = BG_TRANSP;
      end
    end

    if (drawn) begin
      // Boxes set on the previous cell take effect now; end box wins.
      if (s.box[0]) begin
        s.bg = BG_BLACK;
      end
      if (s.box[1]) begin
        s.bg = BG_TRANSP;
      end
      s.box = 2'b00;

      if (code < CODE_SPACE) begin
        ctrl = 1'b1;
        priority if (code[6:3] == 4'h0) begin
          // Alphanumeric colour.
          s.fg      = code[2:0];
          s.mosaic  = 1'b0;
          s.conceal = 1'b0;
        end else if (code[6:3] == 4'h2) begin
          // Mosaic colour.
          s.fg      = code[2:0];
          s.mosaic  = 1'b1;
          s.conceal = 1'b0;
        end else begin
          unique case (code)
            CODE_END_BOX:     s.box[1] = 1'b1;
            CODE_START_BOX: begin
              if (({1'b0, cell_word.column} < LAST_COL) && (nxt != CODE_START_BOX)) begin
                s.box[0] = 1'b1;
              end
            end
            CODE_NORMAL_SIZE: s.dbl = 1'b0;
            CODE_DOUBLE_HGT:  s.dbl = ({1'b0, cell_word.row_index} < LAST_ROW);
            CODE_CONCEAL:     s.conceal = 1'b1;
            CODE_CONTIGUOUS:  s.separated = 1'b0;
            CODE_SEPARATED:   s.separated = 1'b1;
            CODE_BLACK_BG:    s.bg = BG_BLACK;
            CODE_NEW_BG:      s.bg = {1'b0, s.fg};
            CODE_HOLD:        s.hold = 1'b1;
            CODE_RELEASE:     s.hold = 1'b0;
            CODE_RESERVED_0E, CODE_RESERVED_0F, CODE_RESERVED_1B: ctrl = 1'b0;
            default: ;
          endcase
        end
        // Under hold, a control cell repeats the last mosaic drawn.
        if (ctrl && s.hold && s.mosaic) begin
          glyph = s.held;
        end
      end else begin
        glyph = code;
        if (s.conceal && !reveal_hidden) begin
          glyph = CODE_SPACE;
        end
        if (s.mosaic && ((glyph < BLAST_LOW) || (glyph > BLAST_HIGH))) begin
          s.held = glyph;
        end
      end
    end

    blast = (glyph >= BLAST_LOW) && (glyph <= BLAST_HIGH);

    state_next            = s;
    result.glyph          = glyph;
    result.fg_color       = s.fg;
    result.bg_color       = s.bg[2:0];
    result.bg_transparent = transparent_mode || s.bg[3];
    result.draw_mosaic    = s.mosaic && !blast;
    result.separated      = s.separated;
    result.double_height  = s.dbl;
    result.drawn          = drawn;
  end

endmodule

// File: hdl/teletext_row_attribute_decoder_top.sv
// Teletext Level 1 serial attribute decoder, one character cell per word.
// A result appears in the output register in the cycle after its cell is accepted.
// Throughput: one cell per cycle while the output is not stalled; the attribute update is
// a single combinational pass between the attribute registers and the output register.
// Reset (synchronous, rst high) clears the configuration and restores row default attributes.
module teletext_row_attribute_decoder_top import trad_pkg::*; #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 26
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  logic       cfg_data
);

  logic        reveal_hidden;
  logic        transparent_mode;
  logic        subtitle_mode;
  attr_state_t state;
  attr_state_t state_next;
  out_word_t   result;
  logic        in_fire;

  // The output register frees itself in the cycle its word is taken.
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      reveal_hidden    <= 1'b0;
      transparent_mode <= 1'b0;
      subtitle_mode    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REVEAL_HIDDEN:    reveal_hidden    <= cfg_data;
        CFG_TRANSPARENT_MODE: transparent_mode <= cfg_data;
        CFG_SUBTITLE_MODE:    subtitle_mode    <= cfg_data;
        default: ;
      endcase
    end
  end

  trad_cell #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_cell (
    .state           (state),
    .cell_word       (in_data),
    .reveal_hidden   (reveal_hidden),
    .transparent_mode(transparent_mode),
    .subtitle_mode   (subtitle_mode),
    .state_next      (state_next),
    .result          (result)
  );

  // Attribute state moves on with every accepted cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ROW_DEFAULT;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= result;
    end
  end

  // A header cell that does not start a row leaves the attributes alone.
  a_header_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_data.row_start && (in_data.row_index == 5'd0) &&
     (in_data.column <= HEADER_LAST_COL)) |=> (state == $past(state)))
    else $error("header cell changed the attribute state");

  // Undrawn header cells always show a space.
  a_header_space: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.drawn) |-> (out_data.glyph == CODE_SPACE))
    else $error("undrawn cell carries a glyph other than space");

  // Blast-through capitals are never drawn as mosaic.
  a_blast_text: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.draw_mosaic) |->
      ((out_data.glyph < BLAST_LOW) || (out_data.glyph > BLAST_HIGH)))
    else $error("blast-through capital flagged as mosaic");

  // A stalled result blocks further input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while the result register is full and stalled");

endmodule
